// ===== rtl/core/rtwb_pkg.sv =====
// rtwb_pkg: constants, types and sequencer states for route_time_window_bounds
// no dependencies; imported by the route_time_window_bounds module and its test bench
package rtwb_pkg;

    localparam int MAX_STOPS = 64;
    localparam int IDX_W     = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CNT_W     = $clog2(MAX_STOPS + 1);
    localparam int TIME_W    = 24;
    localparam int RES_W     = 32;
    localparam int SUM_W     = 34;
    localparam int SIDX_W    = 6;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FWD,
        S_RD,
        S_BWD
    } t_state;

    typedef struct packed {
        logic signed [RES_W-1:0] earliest;
        logic [TIME_W-1:0]       due;
        logic [TIME_W-1:0]       service;
        logic [TIME_W-1:0]       hop;
    } t_stop_word;

    typedef struct packed {
        logic [TIME_W-1:0] ready;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] service;
        logic [TIME_W-1:0] hop;
        logic [TIME_W-1:0] to_depot;
        logic              last;
    } t_item;

endpackage

// ===== rtl/core/route_time_window_bounds.sv =====
// route_time_window_bounds: earliest/latest service start times along one route, uses rtwb_pkg
// sequence: an input stop is captured in S_IDLE, then updated through the adder in S_FWD;
//   after the last stop each result is a stop memory read in S_RD, then the latest bound in
//   S_BWD, held while the output stalls; the shared adder and one read port set this order
// reset: synchronous active low, clears the sequencer and route counters and sets the depot
//   due time to all ones; the stop memory is not cleared (read only below the count)
module route_time_window_bounds (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel: depot due time
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rtwb_pkg::TIME_W-1:0]     i_cfg_data,
    // stop input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata from bit 0: ready, due, service, dist_from_prev, dist_to_depot
    input  logic [rtwb_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tlast,   // last_stop
    // result output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata from bit 0: stop index, earliest, latest, zero pad
    output logic [rtwb_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                            o_m_tuser,   // overflow
    output logic                            o_m_tlast    // last_result
);
    import rtwb_pkg::*;

    // sequencer and route state
    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count;
    logic signed [RES_W-1:0]  r_run;        // earliest time of the previous stop
    logic [TIME_W-1:0]        r_prev_svc;
    logic [TIME_W-1:0]        r_ret_dist;
    logic                     r_overflow;
    logic [TIME_W-1:0]        r_depot_due;
    logic [IDX_W-1:0]         r_idx;        // stop being walked backward
    logic                     r_first;      // first step of the backward walk
    logic signed [RES_W-1:0]  r_latest;
    logic [TIME_W-1:0]        r_hop_next;   // hop into the stop after r_idx
    t_item                    r_item;

    // stop memory, one read port with registered data
    t_stop_word               r_mem [MAX_STOPS];
    t_stop_word               r_rd_word;

    // output register
    logic                     r_out_valid;
    logic [SIDX_W-1:0]        r_out_idx;
    logic signed [RES_W-1:0]  r_out_e;
    logic signed [RES_W-1:0]  r_out_l;
    logic                     r_out_ovf;
    logic                     r_out_last;

    // control
    logic                     w_in_fire;
    logic                     w_out_free;
    logic                     w_bwd_go;
    logic                     w_room;       // a stop slot is still free
    logic                     w_mem_rd;

    // shared unit
    logic signed [SUM_W-1:0]  w_op_a, w_op_b, w_op_c, w_sum;
    logic signed [RES_W-1:0]  w_sat, w_op_d, w_res;
    logic                     w_mode_max;

    assign o_cfg_ready = 1'b1;
    assign w_room      = (r_count < CNT_W'(MAX_STOPS));
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_in_fire   = i_s_tvalid && o_s_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_s_tvalid) n_state = S_FWD;
            S_FWD:  n_state = r_item.last ? S_RD : S_IDLE;
            S_RD:   n_state = S_BWD;
            S_BWD: begin
                if (w_out_free) n_state = (r_idx == '0) ? S_IDLE : S_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_mem_rd   = 1'b0;
        w_bwd_go   = 1'b0;
        unique case (r_state)
            S_IDLE: o_s_tready = 1'b1;
            S_FWD:  ;
            S_RD:   w_mem_rd = 1'b1;
            S_BWD:  w_bwd_go = w_out_free;
            default: ;
        endcase
    end

    // shared add, saturate and max/min unit
    always_comb begin
        w_op_a     = '0;
        w_op_b     = '0;
        w_op_c     = '0;
        w_op_d     = '0;
        w_mode_max = 1'b1;
        unique case (r_state)
            S_FWD: begin
                // first stop takes its ready time: max(ready, 0)
                if (r_count != '0) begin
                    w_op_a = SUM_W'(r_run);
                    w_op_b = $signed({{(SUM_W-TIME_W){1'b0}}, r_item.hop});
                    w_op_c = $signed({{(SUM_W-TIME_W){1'b0}}, r_prev_svc});
                end
                w_op_d = $signed({{(RES_W-TIME_W){1'b0}}, r_item.ready});
            end
            S_BWD: begin
                w_mode_max = 1'b0;
                if (r_first) begin
                    w_op_a = $signed({{(SUM_W-TIME_W){1'b0}}, r_depot_due});
                    w_op_b = -$signed({{(SUM_W-TIME_W){1'b0}}, r_ret_dist});
                end else begin
                    w_op_a = SUM_W'(r_latest);
                    w_op_b = -$signed({{(SUM_W-TIME_W){1'b0}}, r_hop_next});
                end
                w_op_c = -$signed({{(SUM_W-TIME_W){1'b0}}, r_rd_word.service});
                w_op_d = $signed({{(RES_W-TIME_W){1'b0}}, r_rd_word.due});
            end
            default: ;
        endcase
        w_sum = w_op_a + w_op_b + w_op_c;
        // clamp to the signed 32-bit range
        priority if (w_sum > SUM_W'(64'sh7FFF_FFFF)) begin
            w_sat = {1'b0, {(RES_W-1){1'b1}}};
        end else if (w_sum < -SUM_W'(64'sh8000_0000)) begin
            w_sat = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            w_sat = w_sum[RES_W-1:0];
        end
        if (w_mode_max) w_res = (w_sat > w_op_d) ? w_sat : w_op_d;
        else            w_res = (w_op_d < w_sat) ? w_op_d : w_sat;
    end

    // stop memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_FWD && w_room) begin
            r_mem[r_count[IDX_W-1:0]] <= '{earliest: w_res, due: r_item.due,
                                           service: r_item.service, hop: r_item.hop};
        end
        if (w_mem_rd) r_rd_word <= r_mem[r_idx];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_item <= '{ready: i_s_tdata[23:0], due: i_s_tdata[47:24],
                        service: i_s_tdata[71:48], hop: i_s_tdata[95:72],
                        to_depot: i_s_tdata[119:96], last: i_s_tlast};
        end
        if (w_bwd_go) begin
            r_latest   <= w_res;
            r_hop_next <= r_rd_word.hop;
            r_out_idx  <= SIDX_W'(r_idx);
            r_out_e    <= r_rd_word.earliest;
            r_out_l    <= w_res;
            r_out_ovf  <= r_overflow;
            r_out_last <= (r_idx == '0);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_run       <= '0;
            r_prev_svc  <= '0;
            r_ret_dist  <= '0;
            r_overflow  <= 1'b0;
            r_depot_due <= '1;
            r_idx       <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_depot_due <= i_cfg_data;

            if (w_bwd_go)        r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;

            if (r_state == S_FWD) begin
                if (w_room) begin
                    r_count    <= r_count + 1'b1;
                    r_run      <= w_res;
                    r_prev_svc <= r_item.service;
                end else begin
                    r_overflow <= 1'b1;   // stop dropped, route full
                end
                if (r_item.last) begin
                    // a dropped last stop still supplies the return distance
                    r_ret_dist <= r_item.to_depot;
                    r_first    <= 1'b1;
                    r_idx      <= w_room ? r_count[IDX_W-1:0] : IDX_W'(MAX_STOPS - 1);
                end
            end

            if (w_bwd_go) begin
                r_first <= 1'b0;
                if (r_idx == '0) begin
                    // route done, ready for the next one
                    r_count    <= '0;
                    r_run      <= '0;
                    r_prev_svc <= '0;
                    r_ret_dist <= '0;
                    r_overflow <= 1'b0;
                end else begin
                    r_idx <= r_idx - 1'b1;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - SIDX_W - 2*RES_W){1'b0}}, r_out_l, r_out_e, r_out_idx};
    assign o_m_tuser  = r_out_ovf;
    assign o_m_tlast  = r_out_last;

    // overflow is only possible once the stop memory is full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_count == CNT_W'(MAX_STOPS)))
        else $error("overflow flag set with free stop slots");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_STOPS))
        else $error("stop count beyond capacity");

    // the stop-zero result closes the run
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_bwd_go && r_idx == '0) |=> (o_m_tvalid && o_m_tlast && r_state == S_IDLE))
        else $error("final result not marked last");

    // backward walk never starts on an empty route
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_count != '0))
        else $error("backward walk with no stored stops");

    a_in_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == S_FWD))
        else $error("accepted stop not processed");

endmodule

// ===== verif/route_time_window_bounds_test.sv =====
// route_time_window_bounds_test: self-checking bench for route_time_window_bounds
// depends on rtwb_pkg and the route_time_window_bounds module; a scoreboard class predicts
// earliest/latest bounds per stop and checks every result transaction in order
`timescale 1ns / 1ps

typedef struct {
    bit [5:0] idx;
    longint   earliest;
    longint   latest;
    bit       ovf;
    bit       fin;
} t_bound;

// predicts the per-stop time window bounds of one route and holds them until they come out
class route_bounds_board;
    longint   depot_due;
    int       held;
    longint   run_earliest;
    longint   last_service;
    bit       overflowed;
    longint   earliest_mem[rtwb_pkg::MAX_STOPS];
    longint   due_mem[rtwb_pkg::MAX_STOPS];
    longint   service_mem[rtwb_pkg::MAX_STOPS];
    longint   hop_mem[rtwb_pkg::MAX_STOPS];
    t_bound   expected_bounds[$];
    int       errors;
    int       stops_seen;
    int       routes_seen;
    int       clipped_routes;
    int       bounds_checked;

    function new();
        depot_due      = 64'hFF_FFFF;
        held           = 0;
        run_earliest   = 0;
        last_service   = 0;
        overflowed     = 0;
        errors         = 0;
        stops_seen     = 0;
        routes_seen    = 0;
        clipped_routes = 0;
        bounds_checked = 0;
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function int pending();
        return expected_bounds.size();
    endfunction

    // one stop transaction accepted: forward step, and the backward walk on the last stop
    function void note_stop(rtwb_pkg::t_item s);
        longint ready_t;
        longint arrive;
        longint e;
        longint cand;
        longint latest;
        t_bound b;
        ready_t = longint'(s.ready);
        stops_seen++;
        if (held < rtwb_pkg::MAX_STOPS) begin
            if (held == 0) begin
                e = ready_t;
            end else begin
                arrive = sat32(run_earliest + longint'(s.hop) + last_service);
                e = (arrive > ready_t) ? arrive : ready_t;
            end
            earliest_mem[held] = e;
            due_mem[held]      = longint'(s.due);
            service_mem[held]  = longint'(s.service);
            hop_mem[held]      = longint'(s.hop);
            run_earliest       = e;
            last_service       = longint'(s.service);
            held++;
        end else begin
            overflowed = 1'b1;
        end
        if (!s.last)
            return;
        latest = 0;
        for (int i = held - 1; i >= 0; i--) begin
            if (i == held - 1)
                cand = sat32(depot_due - longint'(s.to_depot) - service_mem[i]);
            else
                cand = sat32(latest - hop_mem[i+1] - service_mem[i]);
            latest = (due_mem[i] < cand) ? due_mem[i] : cand;
            b.idx      = i[5:0];
            b.earliest = earliest_mem[i];
            b.latest   = latest;
            b.ovf      = overflowed;
            b.fin      = (i == 0);
            expected_bounds.insert(expected_bounds.size(), b);
        end
        routes_seen++;
        if (overflowed)
            clipped_routes++;
        held         = 0;
        run_earliest = 0;
        last_service = 0;
        overflowed   = 1'b0;
    endfunction

    function void check_result(bit [5:0] idx, bit [31:0] e, bit [31:0] l, bit ovf, bit fin);
        t_bound    b;
        bit [31:0] exp_e;
        bit [31:0] exp_l;
        bounds_checked++;
        if (expected_bounds.size() == 0) begin
            $error("result for stop %0d with no expected bound waiting", idx);
            errors++;
            return;
        end
        b     = expected_bounds.pop_front();
        exp_e = b.earliest[31:0];
        exp_l = b.latest[31:0];
        if (idx != b.idx) begin
            $error("stop_index expected %0d got %0d", b.idx, idx);
            errors++;
        end
        if (e != exp_e) begin
            $error("earliest bound expected %0d got %0d", $signed(exp_e), $signed(e));
            errors++;
        end
        if (l != exp_l) begin
            $error("latest bound expected %0d got %0d", $signed(exp_l), $signed(l));
            errors++;
        end
        if (ovf != b.ovf) begin
            $error("overflow expected %0d got %0d", b.ovf, ovf);
            errors++;
        end
        if (fin != b.fin) begin
            $error("last_result expected %0d got %0d", b.fin, fin);
            errors++;
        end
    endfunction
endclass

module route_time_window_bounds_test;
    import rtwb_pkg::*;

    localparam logic [23:0] MAX24 = 24'hFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [TIME_W-1:0]     cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // from bit 0: ready, due, service, dist_from_prev, dist_to_depot
    logic                  s_tlast;   // last_stop
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // from bit 0: stop_index, earliest, latest, zero pad
    logic                  m_tuser;   // overflow
    logic                  m_tlast;   // last_result

    route_bounds_board sb;

    // idle rates in percent, and a pending long hold-off for the result side
    int src_idle_pct;
    int rx_stall_pct;
    int hold_off_cycles;
    int depot_writes;

    route_time_window_bounds i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when one is requested
    initial begin : rx_side
        int held;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_cycles > 0) begin
                held            = hold_off_cycles;
                hold_off_cycles = 0;
                m_tready        = 1'b0;
                repeat (held) @(negedge clk);
            end
            m_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // every result transaction is checked against the oldest expected bound
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[5:0], m_tdata[37:6], m_tdata[69:38], m_tuser, m_tlast);
    end

    function automatic t_item mk_stop(logic [23:0] r, logic [23:0] d, logic [23:0] sv,
                                      logic [23:0] h, logic [23:0] dep, logic lst);
        t_item it;
        it.ready    = r;
        it.due      = d;
        it.service  = sv;
        it.hop      = h;
        it.to_depot = dep;
        it.last     = lst;
        return it;
    endfunction

    // mostly full-range values, with zeros, all ones and small times mixed in
    function automatic logic [23:0] rand_time();
        case ($urandom_range(9))
            0:       return 24'h0;
            1:       return MAX24;
            2, 3:    return 24'($urandom_range(4095));
            default: return 24'($urandom());
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_stop(t_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = {it.to_depot, it.hop, it.service, it.due, it.ready};
        s_tlast  = it.last;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_stop(it);
        @(negedge clk);
    endtask

    task automatic send_route(int n);
        for (int i = 0; i < n; i++)
            send_stop(mk_stop(rand_time(), rand_time(), rand_time(), rand_time(),
                              rand_time(), i == n - 1));
    endtask

    // short random routes until about the given number of stops went in
    task automatic send_routes(int n_stops);
        int sent;
        int len;
        sent = 0;
        while (sent < n_stops) begin
            len = $urandom_range(1, 8);
            send_route(len);
            sent += len;
        end
        s_tvalid = 1'b0;
    endtask

    // wait for every expected bound, then let the block settle before touching the register
    task automatic drain();
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_depot_due(logic [23:0] value);
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.depot_due = longint'(value);
        depot_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        sb              = new();
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        src_idle_pct    = 10;
        rx_stall_pct    = 46;
        hold_off_cycles = 0;
        depot_writes    = 0;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed routes, depot due time still at its reset value
        // depot-only route with everything zero, then with everything at full scale
        send_stop(mk_stop(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1));
        send_stop(mk_stop(MAX24, MAX24, MAX24, MAX24, MAX24, 1'b1));
        // depot hop and non-final return distance must be ignored; arrival wins at stop 1,
        // window opening wins at stop 2, a tight due time caps the final stop
        send_stop(mk_stop(24'd100,  24'd5000, 24'd30, 24'd777, 24'd999, 1'b0));
        send_stop(mk_stop(24'd50,   24'd4000, 24'd20, 24'd40,  24'd0,   1'b0));
        send_stop(mk_stop(24'd2000, 24'd2100, 24'd10, 24'd5,   24'd0,   1'b0));
        send_stop(mk_stop(24'd0,    24'd100,  24'd0,  24'd0,   24'd300, 1'b1));
        // full-scale times on every stop push both bounds far out
        for (int i = 0; i < 6; i++)
            send_stop(mk_stop(MAX24, MAX24, MAX24, MAX24, MAX24, i == 5));
        // all zeros with the longest return trip
        send_stop(mk_stop(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        send_stop(mk_stop(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        send_stop(mk_stop(24'h0, 24'h0, 24'h0, 24'h0, MAX24, 1'b1));
        // stop with a closed window (ready at full scale, due zero) followed by an empty stop
        send_stop(mk_stop(MAX24, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0));
        send_stop(mk_stop(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1));
        s_tvalid = 1'b0;
        drain();

        // phase 1: depot closes at zero, sender idles a little, receiver a lot
        write_depot_due(24'h0);
        send_routes(16);
        drain();

        // phase 2: random depot closing time, idling swapped
        src_idle_pct = 46;
        rx_stall_pct = 10;
        write_depot_due(24'($urandom()));
        send_routes(16);
        drain();

        // phase 3: full depot window, no idling; the receiver holds off while a route
        // longer than the stop memory goes in, so two stops are dropped, the last one too,
        // and the next route backs up behind the stalled results
        src_idle_pct    = 0;
        rx_stall_pct    = 0;
        write_depot_due(MAX24);
        hold_off_cycles = 600;
        send_route(MAX_STOPS + 2);
        send_routes(12);
        drain();

        $display("covered %0d routes (%0d over capacity), %0d stops and %0d bound results",
                 sb.routes_seen, sb.clipped_routes, sb.stops_seen, sb.bounds_checked);
        $display("under %0d depot due time writes and three idling mixes", depot_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
